FILE: design/brl_pkg.sv
`timescale 1ns / 1ps

package brl_pkg;

  // Coordinate width of every endpoint and pixel field.
  localparam int COORD_BITS = 10;
  // Error increments hold twice a span; the accumulator is signed.
  localparam int INC_W = COORD_BITS + 2;
  localparam int ERR_W = COORD_BITS + 3;

  // Default depth of the command queue between front and back.
  localparam int QUEUE_DEPTH_DEF = 4;

  // Request type codes.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;

  // Input request payload.
  typedef struct packed {
    logic   req_type;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
  } in_req_t;

  // Output pixel payload.
  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
  } out_pix_t;

  // Registered result of the front's first step: axis chosen, spans known.
  typedef struct packed {
    logic   is_load;
    logic   major_is_x;
    coord_t maj0;
    coord_t maj1;
    coord_t min0;
    coord_t min1;
    coord_t span_maj;
    coord_t span_min;
  } front_stage_t;

  // Classified command passed from the front to the back through the queue.
  typedef struct packed {
    logic             is_load;
    logic             major_is_x;
    coord_t           cur_major;
    coord_t           end_major;
    coord_t           cur_minor;
    logic             minor_down;
    logic [INC_W-1:0] err_inc;
    logic [INC_W-1:0] err_dec;
  } line_cmd_t;

endpackage

FILE: design/bresenham_line_rasterizer_top.sv
`timescale 1ns / 1ps

// Line rasterizer. Each request on the in_ channel is either a load, which
// takes two endpoints and starts a new line (a load during a line drops the
// old one), or a tick, which asks for the next pixel of the current line.
// Every tick of an active line gives one pixel on the out_ channel, with
// last_pixel set on the final one; loads and ticks while idle give nothing.
// A front stage chooses the major axis and orders the endpoints, a command
// queue of QUEUE_DEPTH entries follows, and the back unit holds the line
// state and steps one pixel per clock while the output register can take it.
// Throughput is one request per cycle while nothing stalls. A pixel reaches
// out_valid through the front register, a queue entry and the output register.
// When the receiver stalls, the pixel waits in the output register, the
// queue fills, and in_ready falls once the queue and front stage are full;
// loads and idle ticks keep draining while a pixel waits.
// Reset (rst_n low at a clock edge) empties the queue and the output and
// leaves the block with no active line.
module bresenham_line_rasterizer_top import brl_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output out_pix_t out_pix
);

  logic      fr_valid;
  logic      fr_ready;
  line_cmd_t fr_cmd;
  logic      bk_valid;
  logic      bk_ready;
  line_cmd_t bk_cmd;

  brl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .cmd_valid (fr_valid),
    .cmd_ready (fr_ready),
    .cmd       (fr_cmd)
  );

  brl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_cmd   (fr_cmd),
    .rd_valid (bk_valid),
    .rd_ready (bk_ready),
    .rd_cmd   (bk_cmd)
  );

  brl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (bk_valid),
    .cmd_ready (bk_ready),
    .cmd       (bk_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pix   (out_pix)
  );

endmodule

FILE: design/brl_front.sv
`timescale 1ns / 1ps

module brl_front import brl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_req_t   in_req,
  output logic      cmd_valid,
  input  logic      cmd_ready,
  output line_cmd_t cmd
);

  logic         st_valid_r;
  logic         st_valid_nxt;
  front_stage_t st_r;
  front_stage_t st_nxt;

  coord_t dx;
  coord_t dy;
  logic   swap;

  // The stage takes a new request whenever it is empty or its content moves on.
  assign in_ready = !st_valid_r || cmd_ready;

  // First step: spans of both axes and the choice of the major axis.
  always_comb begin
    dx = (in_req.x_start >= in_req.x_end) ? (in_req.x_start - in_req.x_end)
                                          : (in_req.x_end - in_req.x_start);
    dy = (in_req.y_start >= in_req.y_end) ? (in_req.y_start - in_req.y_end)
                                          : (in_req.y_end - in_req.y_start);
    st_nxt.is_load    = (in_req.req_type == REQ_LOAD);
    st_nxt.major_is_x = (dx > dy);
    if (dx > dy) begin
      st_nxt.maj0     = in_req.x_start;
      st_nxt.maj1     = in_req.x_end;
      st_nxt.min0     = in_req.y_start;
      st_nxt.min1     = in_req.y_end;
      st_nxt.span_maj = dx;
      st_nxt.span_min = dy;
    end else begin
      st_nxt.maj0     = in_req.y_start;
      st_nxt.maj1     = in_req.y_end;
      st_nxt.min0     = in_req.x_start;
      st_nxt.min1     = in_req.x_end;
      st_nxt.span_maj = dy;
      st_nxt.span_min = dx;
    end
  end

  always_comb begin
    st_valid_nxt = st_valid_r;
    if (in_valid && in_ready) begin
      st_valid_nxt = 1'b1;
    end else if (cmd_ready) begin
      st_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else begin
      st_valid_r <= st_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      st_r <= st_nxt;
    end
  end

  // Second step: order the endpoints so the major coordinate rises.
  always_comb begin
    swap           = (st_r.maj0 > st_r.maj1);
    cmd.is_load    = st_r.is_load;
    cmd.major_is_x = st_r.major_is_x;
    cmd.cur_major  = swap ? st_r.maj1 : st_r.maj0;
    cmd.end_major  = swap ? st_r.maj0 : st_r.maj1;
    cmd.cur_minor  = swap ? st_r.min1 : st_r.min0;
    cmd.minor_down = swap ? (st_r.min1 > st_r.min0) : (st_r.min0 > st_r.min1);
    cmd.err_inc    = {1'b0, st_r.span_min, 1'b0};
    cmd.err_dec    = {1'b0, st_r.span_maj, 1'b0};
  end

  assign cmd_valid = st_valid_r;

endmodule

FILE: design/brl_queue.sv
`timescale 1ns / 1ps

module brl_queue import brl_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  line_cmd_t wr_cmd,
  output logic      rd_valid,
  input  logic      rd_ready,
  output line_cmd_t rd_cmd
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  line_cmd_t        entry_r [DEPTH];
  logic [IDX_W-1:0] wr_ptr_r;
  logic [IDX_W-1:0] wr_ptr_nxt;
  logic [IDX_W-1:0] rd_ptr_r;
  logic [IDX_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             push;
  logic             pop;

  assign wr_ready = (count_r != CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_cmd   = entry_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

FILE: design/brl_back.sv
`timescale 1ns / 1ps

module brl_back import brl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  line_cmd_t cmd,
  output logic      out_valid,
  input  logic      out_ready,
  output out_pix_t  out_pix
);

  logic                    active_r;
  logic                    active_nxt;
  logic                    major_is_x_r;
  logic                    major_is_x_nxt;
  coord_t                  cur_major_r;
  coord_t                  cur_major_nxt;
  coord_t                  end_major_r;
  coord_t                  end_major_nxt;
  coord_t                  cur_minor_r;
  coord_t                  cur_minor_nxt;
  logic                    minor_down_r;
  logic                    minor_down_nxt;
  logic signed [ERR_W-1:0] err_acc_r;
  logic signed [ERR_W-1:0] err_acc_nxt;
  logic [INC_W-1:0]        err_inc_r;
  logic [INC_W-1:0]        err_inc_nxt;
  logic [INC_W-1:0]        err_dec_r;
  logic [INC_W-1:0]        err_dec_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  out_pix_t                out_pix_r;
  out_pix_t                out_pix_nxt;

  logic                    pop;
  logic                    emit;
  logic                    last;
  logic signed [ERR_W-1:0] err_sum;

  // A load or an idle tick never needs the output slot; a pixel does.
  assign cmd_ready = cmd.is_load || !active_r || !out_valid_r || out_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign emit      = pop && !cmd.is_load && active_r;
  assign last      = (cur_major_r == end_major_r);
  assign err_sum   = err_acc_r + $signed({1'b0, err_inc_r});

  // Line state: load a new line or advance one pixel.
  always_comb begin
    active_nxt     = active_r;
    major_is_x_nxt = major_is_x_r;
    cur_major_nxt  = cur_major_r;
    end_major_nxt  = end_major_r;
    cur_minor_nxt  = cur_minor_r;
    minor_down_nxt = minor_down_r;
    err_acc_nxt    = err_acc_r;
    err_inc_nxt    = err_inc_r;
    err_dec_nxt    = err_dec_r;
    if (pop && cmd.is_load) begin
      active_nxt     = 1'b1;
      major_is_x_nxt = cmd.major_is_x;
      cur_major_nxt  = cmd.cur_major;
      end_major_nxt  = cmd.end_major;
      cur_minor_nxt  = cmd.cur_minor;
      minor_down_nxt = cmd.minor_down;
      err_acc_nxt    = '0;
      err_inc_nxt    = cmd.err_inc;
      err_dec_nxt    = cmd.err_dec;
    end else if (emit) begin
      err_acc_nxt = err_sum;
      if (err_sum > 0) begin
        cur_minor_nxt = minor_down_r ? cur_minor_r - 1'b1 : cur_minor_r + 1'b1;
        err_acc_nxt   = err_sum - $signed({1'b0, err_dec_r});
      end
      cur_major_nxt = cur_major_r + 1'b1;
      if (last) begin
        active_nxt = 1'b0;
      end
    end
  end

  // Output register: filled on a pixel, emptied when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_pix_nxt   = out_pix_r;
    if (emit) begin
      out_valid_nxt          = 1'b1;
      out_pix_nxt.pixel_x    = major_is_x_r ? cur_major_r : cur_minor_r;
      out_pix_nxt.pixel_y    = major_is_x_r ? cur_minor_r : cur_major_r;
      out_pix_nxt.last_pixel = last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    major_is_x_r <= major_is_x_nxt;
    cur_major_r  <= cur_major_nxt;
    end_major_r  <= end_major_nxt;
    cur_minor_r  <= cur_minor_nxt;
    minor_down_r <= minor_down_nxt;
    err_acc_r    <= err_acc_nxt;
    err_inc_r    <= err_inc_nxt;
    err_dec_r    <= err_dec_nxt;
    out_pix_r    <= out_pix_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_pix   = out_pix_r;

endmodule
